// ----- rtl/core/rfc_pkg.sv -----
// request frame checker package: status and register codes, configuration,
// header and result types, crc-32 byte update
// no dependencies
package rfc_pkg;

  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned CRC_SPAN     = 20;
  localparam int unsigned CFG_ADDR_W   = 5;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FRAME    = 2'd1,
    ST_CAPACITY = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_MAGIC    = 3'd0,
    REG_VERSION  = 3'd1,
    REG_KIND_LO  = 3'd2,
    REG_KIND_HI  = 3'd3,
    REG_RESP_MSK = 3'd4,
    REG_LIMIT    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] kind_lo;
    logic [15:0] kind_hi;
    logic [15:0] resp_mask;
    logic [15:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] kind;
    logic [31:0] sequence_nr;
    logic [31:0] length;
    logic [31:0] code;
    logic [31:0] crc_rx;
    logic [31:0] crc_run;
  } hdr_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] kind;
    logic [31:0] sequence_nr;
    logic [31:0] size;
  } res_t;

  localparam cfg_t CFG_RESET = '{resp_mask: 16'h8000, default: '0};
  localparam hdr_t HDR_CLEAR = '{crc_run: 32'hFFFF_FFFF, default: '0};

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/rfc_req_if.sv -----
// request channel: one frame byte per request with an end-of-frame flag
// no dependencies
interface rfc_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ----- rtl/core/rfc_res_if.sv -----
// result channel: frame status and the captured header fields
// no dependencies
interface rfc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  check_status;
  logic [15:0] frame_kind;
  logic [31:0] sequence_number;
  logic [31:0] payload_size;

  modport source (output valid, output check_status, output frame_kind,
                  output sequence_number, output payload_size, input ready);
  modport sink   (input valid, input check_status, input frame_kind,
                  input sequence_number, input payload_size, output ready);
endinterface

// ----- rtl/core/rfc_regs.sv -----
// apb configuration registers of the request frame checker
// depends on rfc_pkg
module rfc_regs import rfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e idx;
  logic     wr_en;

  assign idx    = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MAGIC:    cfg_d.magic     = pwdata;
        REG_VERSION:  cfg_d.version   = pwdata[15:0];
        REG_KIND_LO:  cfg_d.kind_lo   = pwdata[15:0];
        REG_KIND_HI:  cfg_d.kind_hi   = pwdata[15:0];
        REG_RESP_MSK: cfg_d.resp_mask = pwdata[15:0];
        REG_LIMIT:    cfg_d.limit     = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAGIC:    prdata = cfg_q.magic;
      REG_VERSION:  prdata = {16'b0, cfg_q.version};
      REG_KIND_LO:  prdata = {16'b0, cfg_q.kind_lo};
      REG_KIND_HI:  prdata = {16'b0, cfg_q.kind_hi};
      REG_RESP_MSK: prdata = {16'b0, cfg_q.resp_mask};
      REG_LIMIT:    prdata = {16'b0, cfg_q.limit};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/rfc_judge.sv -----
// end-of-frame checks: header fields, length and crc against configuration
// depends on rfc_pkg
module rfc_judge import rfc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  hdr_t               hdr_i,
  input  logic [LENGTH_BITS:0] pos_i,
  input  cfg_t               cfg_i,
  output status_e            status_o
);

  logic [15:0] base_kind;
  logic [32:0] want_count;
  logic [32:0] got_count;

  assign base_kind  = hdr_i.kind & ~cfg_i.resp_mask;
  assign want_count = {1'b0, hdr_i.length} + 33'(HEADER_BYTES);
  assign got_count  = 33'(pos_i);

  always_comb begin
    if (pos_i < (LENGTH_BITS + 1)'(HEADER_BYTES)) begin
      status_o = ST_FRAME;
    end else if (hdr_i.magic != cfg_i.magic || hdr_i.version != cfg_i.version) begin
      status_o = ST_FRAME;
    end else if (base_kind < cfg_i.kind_lo || base_kind > cfg_i.kind_hi ||
                 (hdr_i.kind & cfg_i.resp_mask) != 16'b0 || hdr_i.code != 32'b0) begin
      status_o = ST_FRAME;
    end else if (hdr_i.length > {16'b0, cfg_i.limit}) begin
      status_o = ST_CAPACITY;
    end else if (want_count != got_count) begin
      status_o = ST_FRAME;
    end else if (~hdr_i.crc_run != hdr_i.crc_rx) begin
      status_o = ST_CHECKSUM;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

// ----- rtl/core/request_frame_checker.sv -----
// Request frame checker. Takes one frame byte per cycle, back to back, with no
// gaps needed between frames: header bytes update the header capture and bytes
// outside the received crc field update the reflected crc-32, in the cycle each
// is accepted. On the byte flagged as the end of the frame the updated header is
// copied to a hold stage and the frame state is cleared; the checks on the hold
// stage then load into the result register once it is free. Input stalls only
// while the hold stage is full and the result register holds a result that is
// not being taken. The byte counter is LENGTH_BITS+1 bits wide and saturates.
// depends on rfc_pkg, rfc_req_if, rfc_res_if, rfc_regs, rfc_judge
module request_frame_checker import rfc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rfc_req_if.sink               req_i,
  rfc_res_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned PW = LENGTH_BITS + 1;

  cfg_t          cfg;
  logic [PW-1:0] pos_q, pos_d, pos_next;
  hdr_t          hdr_q, hdr_d, upd;
  logic [4:0]    hp;
  logic [7:0]    b;
  logic          accept;
  logic          out_free;

  logic          snap_valid_q, snap_valid_d;
  hdr_t          snap_q;
  logic [PW-1:0] snap_pos_q;

  status_e       status;
  logic          out_valid_q, out_valid_d;
  res_t          out_q;

  rfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfc_judge #(.LENGTH_BITS(LENGTH_BITS)) u_judge (
    .hdr_i    (snap_q),
    .pos_i    (snap_pos_q),
    .cfg_i    (cfg),
    .status_o (status)
  );

  assign out_free    = !out_valid_q || res_o.ready;
  assign req_i.ready = !snap_valid_q || out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign b           = req_i.frame_byte;
  assign hp          = pos_q[4:0];
  assign pos_next    = (pos_q == '1) ? pos_q : pos_q + 1'b1;

  // header capture and crc update for the incoming byte
  always_comb begin
    upd = hdr_q;
    if (pos_q < PW'(HEADER_BYTES)) begin
      case (hp) inside
        [5'd0:5'd3]:   upd.magic[{hp[1:0], 3'b000} +: 8]       = b;
        [5'd4:5'd5]:   upd.version[{hp[0], 3'b000} +: 8]       = b;
        [5'd6:5'd7]:   upd.kind[{hp[0], 3'b000} +: 8]          = b;
        [5'd8:5'd11]:  upd.sequence_nr[{hp[1:0], 3'b000} +: 8] = b;
        [5'd12:5'd15]: upd.length[{hp[1:0], 3'b000} +: 8]      = b;
        [5'd16:5'd19]: upd.code[{hp[1:0], 3'b000} +: 8]        = b;
        default:       upd.crc_rx[{hp[1:0], 3'b000} +: 8]      = b;
      endcase
    end
    if (pos_q < PW'(CRC_SPAN) || pos_q >= PW'(HEADER_BYTES)) begin
      upd.crc_run = crc_byte(hdr_q.crc_run, b);
    end
  end

  always_comb begin
    hdr_d        = hdr_q;
    pos_d        = pos_q;
    snap_valid_d = snap_valid_q;
    if (snap_valid_q && out_free) begin
      snap_valid_d = 1'b0;
    end
    if (accept) begin
      if (req_i.frame_end) begin
        hdr_d        = HDR_CLEAR;
        pos_d        = '0;
        snap_valid_d = 1'b1;
      end else begin
        hdr_d = upd;
        pos_d = pos_next;
      end
    end
  end

  assign out_valid_d = snap_valid_q ? 1'b1 : (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q        <= HDR_CLEAR;
      pos_q        <= '0;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hdr_q        <= hdr_d;
      pos_q        <= pos_d;
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.frame_end) begin
      snap_q     <= upd;
      snap_pos_q <= pos_next;
    end
    if (snap_valid_q && out_free) begin
      out_q.status      <= status;
      out_q.kind        <= snap_q.kind;
      out_q.sequence_nr <= snap_q.sequence_nr;
      out_q.size        <= snap_q.length;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.check_status    = out_q.status;
  assign res_o.frame_kind      = out_q.kind;
  assign res_o.sequence_number = out_q.sequence_nr;
  assign res_o.payload_size    = out_q.size;

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_q && !out_free) |-> !req_i.ready)
    else $error("request taken while hold stage and result register are full");

  a_result_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(snap_valid_q))
    else $error("result offered without a finished frame");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.frame_end) |=> (pos_q == '0 && hdr_q.crc_run == 32'hFFFF_FFFF))
    else $error("frame state not cleared after last byte");

  a_short_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_q && out_free && snap_pos_q < PW'(HEADER_BYTES))
      |=> (out_q.status == ST_FRAME))
    else $error("short frame not reported as frame error");

endmodule

// ----- tb/request_frame_checker_tb.sv -----
// testbench for request_frame_checker: directed frame table, then random frames
// under random register settings, results checked against typed table rows or a byte-level
// frame predictor; depends on rfc_pkg, rfc_req_if, rfc_res_if and request_frame_checker
module request_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfc_pkg::*;

  localparam int unsigned LENGTH_BITS  = 16;
  localparam int unsigned COUNT_CAP    = (1 << (LENGTH_BITS + 1)) - 1;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned PHASE_BYTES  = 80;
  localparam int unsigned PHASE_FRAMES = 3;
  localparam logic [31:0] DIR_MAGIC    = 32'h5AA5_C33C;
  localparam logic [15:0] DIR_VER      = 16'h0102;

  typedef struct packed {
    int          cfg;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] kind;
    logic [31:0] seq_nr;
    logic [31:0] len;
    logic [31:0] code;
    int          pay_n;
    int          cut;
    bit          crc_bad;
    bit          typed;
    status_e     status;
  } frame_row_t;

  localparam cfg_t DIR_CFGS [4] = '{
    CFG_RESET,
    '{magic: DIR_MAGIC, version: DIR_VER, kind_lo: 16'h0001, kind_hi: 16'h0100,
      resp_mask: 16'h8000, limit: 16'd16},
    '{magic: 32'hFFFF_FFFF, version: 16'hFFFF, kind_lo: 16'hFFFF, kind_hi: 16'h0000,
      resp_mask: 16'h0000, limit: 16'hFFFF},
    '{magic: 32'h0, version: 16'h0, kind_lo: 16'h0000, kind_hi: 16'hFFFF,
      resp_mask: 16'hFFFF, limit: 16'hFFFF}
  };

  // cfg, magic, version, kind, sequence, length, code, payload, cut, bad crc, typed, status
  localparam frame_row_t DIR_ROWS [21] = '{
    '{0, 32'h0, 16'h0, 16'h0000, 32'h0, 32'd0, 32'h0, 0, 0, 1'b0, 1'b1, ST_OK},
    '{0, 32'h0, 16'h0, 16'h0000, 32'h0, 32'd0, 32'h0, 0, 1, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h0001, 32'h1, 32'd0, 32'h0, 0, 0, 1'b0, 1'b1, ST_OK},
    '{1, DIR_MAGIC, DIR_VER, 16'h0100, 32'hFFFF_FFFF, 32'd16, 32'h0, 16, 0, 1'b0, 1'b1, ST_OK},
    '{1, 32'hFFFF_FFFF, DIR_VER, 16'h0005, 32'd3, 32'd4, 32'h0, 4, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, 16'hFFFF, 16'h0005, 32'd3, 32'd4, 32'h0, 4, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h0000, 32'd3, 32'd4, 32'h0, 4, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h0101, 32'd3, 32'd4, 32'h0, 4, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h8005, 32'd3, 32'd4, 32'h0, 4, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h0005, 32'd3, 32'd4, 32'h8000_0000, 4, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h0005, 32'd3, 32'd17, 32'h0, 17, 0, 1'b0, 1'b1, ST_CAPACITY},
    '{1, DIR_MAGIC, DIR_VER, 16'h0005, 32'd3, 32'hFFFF_FFFF, 32'h0, 0, 0, 1'b0, 1'b1, ST_CAPACITY},
    '{1, DIR_MAGIC, DIR_VER, 16'h0005, 32'd3, 32'd10, 32'h0, 9, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h0005, 32'd3, 32'd10, 32'h0, 11, 0, 1'b0, 1'b1, ST_FRAME},
    '{1, DIR_MAGIC, DIR_VER, 16'h0005, 32'd3, 32'd10, 32'h0, 10, 0, 1'b1, 1'b1, ST_CHECKSUM},
    '{1, DIR_MAGIC, DIR_VER, 16'h0042, 32'hDEAD_BEEF, 32'd8, 32'h0, 8, 23, 1'b0, 1'b0, ST_OK},
    '{1, DIR_MAGIC, DIR_VER, 16'h0042, 32'h1234_5678, 32'd8, 32'h0, 8, 14, 1'b0, 1'b0, ST_OK},
    '{1, DIR_MAGIC, DIR_VER, 16'h00FF, 32'h0BAD_F00D, 32'd7, 32'h0, 7, 0, 1'b0, 1'b0, ST_OK},
    '{2, 32'hFFFF_FFFF, 16'hFFFF, 16'h1234, 32'd1, 32'd3, 32'h0, 3, 0, 1'b0, 1'b1, ST_FRAME},
    '{3, 32'h0, 16'h0, 16'h0000, 32'd9, 32'd5, 32'h0, 5, 0, 1'b0, 1'b1, ST_OK},
    '{3, 32'h0, 16'h0, 16'h8000, 32'd9, 32'd5, 32'h0, 5, 0, 1'b0, 1'b1, ST_FRAME}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  rfc_req_if req_ch ();
  rfc_res_if res_ch ();

  request_frame_checker #(.LENGTH_BITS(LENGTH_BITS)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [31:0]  sh_magic;
  logic [15:0]  sh_version;
  logic [15:0]  sh_kind_lo;
  logic [15:0]  sh_kind_hi;
  logic [15:0]  sh_resp_mask;
  logic [15:0]  sh_limit;

  int unsigned  fc_count;
  logic [31:0]  fc_crc;
  logic [191:0] fc_hdr;

  res_t         verdicts_due [$];
  logic [7:0]   frame_bytes [$];
  int           fails;
  int           tx_idle_pct;
  int           rx_idle_pct;
  int           rx_stall_left;
  int           quiet_cycles;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    fc_count = 0;
    fc_crc   = 32'hFFFF_FFFF;
    fc_hdr   = '0;
  endfunction

  // frame predictor: one byte in, a verdict out on the end-of-frame byte
  function automatic bit absorb_byte(input logic [7:0] b, input logic last, output res_t v);
    logic [31:0] magic, seq_nr, len, code, crc_rx;
    logic [15:0] version, kind, base;
    status_e     st;
    if (fc_count < HEADER_BYTES) begin
      fc_hdr[fc_count*8 +: 8] = b;
      if (fc_count < CRC_SPAN) fc_crc = crc32_step(fc_crc, b);
    end else begin
      fc_crc = crc32_step(fc_crc, b);
    end
    if (fc_count < COUNT_CAP) fc_count++;
    v = '0;
    if (!last) return 1'b0;
    magic   = fc_hdr[31:0];
    version = fc_hdr[47:32];
    kind    = fc_hdr[63:48];
    seq_nr  = fc_hdr[95:64];
    len     = fc_hdr[127:96];
    code    = fc_hdr[159:128];
    crc_rx  = fc_hdr[191:160];
    base    = kind & ~sh_resp_mask;
    if (fc_count < HEADER_BYTES) st = ST_FRAME;
    else if (magic != sh_magic || version != sh_version) st = ST_FRAME;
    else if (base < sh_kind_lo || base > sh_kind_hi || (kind & sh_resp_mask) != 16'd0 ||
             code != 32'd0) st = ST_FRAME;
    else if (len > {16'd0, sh_limit}) st = ST_CAPACITY;
    else if (64'(HEADER_BYTES) + 64'(len) != 64'(fc_count)) st = ST_FRAME;
    else if (~fc_crc != crc_rx) st = ST_CHECKSUM;
    else st = ST_OK;
    v.status      = st;
    v.kind        = kind;
    v.sequence_nr = seq_nr;
    v.size        = len;
    clear_frame_state();
    return 1'b1;
  endfunction

  function automatic void build_frame(input logic [31:0] magic, input logic [15:0] version,
                                      input logic [15:0] kind, input logic [31:0] seq_nr,
                                      input logic [31:0] len, input logic [31:0] code,
                                      input int pay_n, input int cut, input bit crc_bad);
    logic [159:0] h;
    logic [31:0]  c;
    logic [31:0]  crc_rx;
    logic [7:0]   pay [$];
    h = {code, len, seq_nr, kind, version, magic};
    c = 32'hFFFF_FFFF;
    frame_bytes.delete();
    for (int i = 0; i < 20; i++) begin
      frame_bytes.push_back(h[i*8 +: 8]);
      c = crc32_step(c, h[i*8 +: 8]);
    end
    for (int i = 0; i < pay_n; i++) begin
      pay.push_back(8'($urandom));
      c = crc32_step(c, pay[i]);
    end
    crc_rx = ~c;
    if (crc_bad) crc_rx ^= ($urandom | 32'd1);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(crc_rx[i*8 +: 8]);
    foreach (pay[i]) frame_bytes.push_back(pay[i]);
    while (cut > 0 && frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                           input res_t typed_v);
    res_t v;
    if (tx_idle_pct > 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.frame_byte <= b;
    req_ch.frame_end  <= last;
    do @(posedge clk_i); while (!req_ch.ready);
    if (absorb_byte(b, last, v)) verdicts_due.push_back(typed ? typed_v : v);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input bit typed, input res_t typed_v);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1, typed, typed_v);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input cfg_reg_e r, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_reg(input cfg_reg_e r, input logic [31:0] val);
    logic [31:0] m, wv, rd;
    m  = (r == REG_MAGIC) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    wv = val & m;
    apb_access(1'b1, r, wv, rd);
    apb_access(1'b0, r, 32'd0, rd);
    if (rd !== wv) begin
      $error("%s readback: expected %0h, actual %0h", r.name(), wv, rd);
      fails++;
    end
    case (r)
      REG_MAGIC:    sh_magic     = wv;
      REG_VERSION:  sh_version   = wv[15:0];
      REG_KIND_LO:  sh_kind_lo   = wv[15:0];
      REG_KIND_HI:  sh_kind_hi   = wv[15:0];
      REG_RESP_MSK: sh_resp_mask = wv[15:0];
      REG_LIMIT:    sh_limit     = wv[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_t c);
    set_reg(REG_MAGIC, c.magic);
    set_reg(REG_VERSION, {16'd0, c.version});
    set_reg(REG_KIND_LO, {16'd0, c.kind_lo});
    set_reg(REG_KIND_HI, {16'd0, c.kind_hi});
    set_reg(REG_RESP_MSK, {16'd0, c.resp_mask});
    set_reg(REG_LIMIT, {16'd0, c.limit});
  endtask

  task automatic rand_config();
    cfg_t        c;
    logic [15:0] a, b;
    int          sel;
    a   = 16'($urandom);
    b   = 16'($urandom);
    sel = $urandom_range(9, 0);
    c.magic   = (sel == 0) ? 32'hFFFF_FFFF : (sel == 1) ? 32'h0 : $urandom;
    c.version = 16'($urandom);
    sel = $urandom_range(9, 0);
    if (sel == 0) begin
      c.kind_lo = 16'h0000;
      c.kind_hi = 16'hFFFF;
    end else if (sel == 1) begin
      c.kind_lo = (a > b) ? a : b;
      c.kind_hi = (a > b) ? b : a;
    end else begin
      c.kind_lo = (a > b) ? b : a;
      c.kind_hi = (a > b) ? a : b;
    end
    sel = $urandom_range(9, 0);
    c.resp_mask = (sel < 6) ? 16'h8000 : (sel == 6) ? 16'h0000 :
                  (sel == 7) ? 16'hFFFF : 16'($urandom);
    sel = $urandom_range(9, 0);
    c.limit = (sel < 6) ? 16'($urandom_range(48, 0)) : (sel == 6) ? 16'h0000 :
              (sel == 7) ? 16'hFFFF : 16'($urandom);
    set_config(c);
  endtask

  // mostly well-formed requests with random content, some noise and broken frames
  task automatic rand_frame();
    logic [31:0] magic, seq_nr, len, code;
    logic [15:0] version, kind;
    int          pay_n, cut, sel;
    bit          bad;
    if ($urandom_range(99, 0) < 12) begin
      frame_bytes.delete();
      repeat ($urandom_range(40, 1)) frame_bytes.push_back(8'($urandom));
    end else begin
      magic   = ($urandom_range(99, 0) < 5) ? $urandom : sh_magic;
      version = ($urandom_range(99, 0) < 5) ? 16'($urandom) : sh_version;
      kind    = (sh_kind_lo <= sh_kind_hi) ? 16'($urandom_range(sh_kind_hi, sh_kind_lo)) :
                16'($urandom);
      if ($urandom_range(99, 0) < 90) kind &= ~sh_resp_mask;
      seq_nr = $urandom;
      code   = ($urandom_range(99, 0) < 5) ? $urandom : 32'd0;
      sel    = $urandom_range(99, 0);
      if (sel < 80) len = $urandom_range((sh_limit < 16'd20) ? 32'(sh_limit) : 32'd20, 0);
      else if (sel < 90) len = {16'd0, sh_limit} + 32'd1;
      else len = $urandom;
      pay_n = (len <= 32'd20) ? int'(len) : int'($urandom_range(20, 0));
      if ($urandom_range(99, 0) < 8) pay_n = $urandom_range(pay_n + 2, 0);
      cut = ($urandom_range(99, 0) < 5) ? $urandom_range(23, 1) : 0;
      bad = $urandom_range(99, 0) < 8;
      build_frame(magic, version, kind, seq_nr, len, code, pay_n, cut, bad);
    end
    send_frame(1'b0, '0);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    int bytes_sent, frames_sent;
    wait_drained();
    rand_config();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    bytes_sent  = 0;
    frames_sent = 0;
    while (bytes_sent < PHASE_BYTES || frames_sent < PHASE_FRAMES) begin
      if ((tx_pct > 0 || rx_pct > 0) && $urandom_range(99, 0) < 4) wait_drained();
      rand_frame();
      bytes_sent += frame_bytes.size();
      frames_sent++;
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_stall_left > 0) begin
      res_ch.ready <= 1'b0;
      rx_stall_left--;
    end else if (rx_idle_pct > 0 && $urandom_range(99, 0) < rx_idle_pct) begin
      res_ch.ready <= 1'b0;
      rx_stall_left = $urandom_range(12, 0);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t v;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no request pending");
        fails++;
      end else begin
        v = verdicts_due.pop_front();
        if (res_ch.check_status !== v.status) begin
          $error("check_status: expected %0d, actual %0d", v.status, res_ch.check_status);
          fails++;
        end
        if (res_ch.frame_kind !== v.kind) begin
          $error("frame_kind: expected %0h, actual %0h", v.kind, res_ch.frame_kind);
          fails++;
        end
        if (res_ch.sequence_number !== v.sequence_nr) begin
          $error("sequence_number: expected %0h, actual %0h", v.sequence_nr,
                 res_ch.sequence_number);
          fails++;
        end
        if (res_ch.payload_size !== v.size) begin
          $error("payload_size: expected %0h, actual %0h", v.size, res_ch.payload_size);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL request_frame_checker");
        $finish;
      end
    end
  end

  initial begin
    frame_row_t row;
    res_t       tv;
    int         cur_cfg;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.frame_byte = '0;
    req_ch.frame_end  = 1'b0;
    res_ch.ready      = 1'b0;
    fails             = 0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    rx_stall_left     = 0;
    quiet_cycles      = 0;
    sh_magic          = CFG_RESET.magic;
    sh_version        = CFG_RESET.version;
    sh_kind_lo        = CFG_RESET.kind_lo;
    sh_kind_hi        = CFG_RESET.kind_hi;
    sh_resp_mask      = CFG_RESET.resp_mask;
    sh_limit          = CFG_RESET.limit;
    clear_frame_state();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    cur_cfg = 0;
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      row = DIR_ROWS[i];
      if (row.cfg != cur_cfg) begin
        wait_drained();
        set_config(DIR_CFGS[row.cfg]);
        cur_cfg = row.cfg;
      end
      tx_idle_pct = 20;
      rx_idle_pct = tx_idle_pct;
      tv.status      = row.status;
      tv.kind        = row.kind;
      tv.sequence_nr = row.seq_nr;
      tv.size        = row.len;
      build_frame(row.magic, row.version, row.kind, row.seq_nr, row.len, row.code,
                  row.pay_n, row.cut, row.crc_bad);
      send_frame(row.typed, tv);
    end

    run_phase(30, 30);
    run_phase(0, 40);
    run_phase(40, 0);
    run_phase(0, 0);

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (fails == 0) begin
      $display("PASS request_frame_checker");
    end else begin
      $display("FAIL request_frame_checker");
    end
    $finish;
  end

endmodule
